/* rtl/fdiq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdiq_pkg
// Shared types, constants and helpers for the frame deframer and its queue.
// ----------------------------------------------------------------------------
package fdiq_pkg;

  localparam int QUEUE_DEPTH    = 8;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FRAME_LOOKBACK = 4;
  localparam int BYTE_W         = 8;
  localparam int ENTRY_W        = 3 * BYTE_W;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_BAD_START  = 3'd2,
    ST_NOT_FOR_US = 3'd3,
    ST_FULL       = 3'd4,
    ST_POPPED     = 3'd5,
    ST_POP_EMPTY  = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE   = 2'd0,
    CFG_END_BYTE     = 2'd1,
    CFG_NODE_ADDRESS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic do_byte;
    logic rd_issue;
    logic do_pop;
    logic do_pop_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic item_pop;
    logic q_empty;
  } dp_sts_t;

  function automatic logic [QPTR_W-1:0] ring_next(input logic [QPTR_W-1:0] i);
    logic [QPTR_W-1:0] n;
    if (i == QPTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = i + QPTR_W'(1);
    end
    return n;
  endfunction

endpackage

/* rtl/fdiq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdiq_ctrl
// Sequencer: accepts an item, runs it through the datapath, steps pop reads.
// ----------------------------------------------------------------------------
module fdiq_ctrl
  import fdiq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.item_pop) begin
          cmd.do_byte = 1'b1;
          state_nxt   = S_IDLE;
        end else if (sts.q_empty) begin
          cmd.do_pop_empty = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_POP;
        end
      end
      S_POP: begin
        cmd.do_pop = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/fdiq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdiq_dp
// Datapath: config registers, byte history, frame checks, ring queue, outputs.
// ----------------------------------------------------------------------------
module fdiq_dp
  import fdiq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_op,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [BYTE_W-1:0]    out_msg_from,
  output logic [BYTE_W-1:0]    out_msg_to,
  output logic [BYTE_W-1:0]    out_msg_type,
  output logic                 out_available
);

  logic [BYTE_W-1:0]  start_byte_r;
  logic [BYTE_W-1:0]  end_byte_r;
  logic [BYTE_W-1:0]  node_address_r;

  op_t                op_r;
  logic [BYTE_W-1:0]  byte_r;

  logic [BYTE_W-1:0]  recent_r [FRAME_LOOKBACK];
  logic [QPTR_W-1:0]  wr_idx_r;
  logic [QPTR_W-1:0]  wr_idx_nxt;
  logic [QPTR_W-1:0]  rd_idx_r;
  logic [QPTR_W-1:0]  rd_idx_nxt;
  logic [ENTRY_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  logic               out_valid_r;
  status_t            status_r;
  status_t            status_nxt;
  logic [ENTRY_W-1:0] msg_r;
  logic [ENTRY_W-1:0] msg_nxt;
  logic               avail_r;

  logic [QPTR_W-1:0]  wr_next;
  logic [QPTR_W-1:0]  rd_next;
  logic               q_empty;
  logic               q_full;
  status_t            byte_status;
  logic               push;
  logic               load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= '0;
      end_byte_r     <= '0;
      node_address_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_BYTE:   start_byte_r   <= cfg_data;
        CFG_END_BYTE:     end_byte_r     <= cfg_data;
        CFG_NODE_ADDRESS: node_address_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_op);
      byte_r <= in_rx_byte;
    end
  end

  assign wr_next = ring_next(wr_idx_r);
  assign rd_next = ring_next(rd_idx_r);
  assign q_empty = (wr_idx_r == rd_idx_r);
  assign q_full  = (wr_next == rd_idx_r);

  always_comb begin
    if (byte_r != end_byte_r) begin
      byte_status = ST_NONE;
    end else if (recent_r[0] != start_byte_r) begin
      byte_status = ST_BAD_START;
    end else if (recent_r[2] != node_address_r) begin
      byte_status = ST_NOT_FOR_US;
    end else if (q_full) begin
      byte_status = ST_FULL;
    end else begin
      byte_status = ST_QUEUED;
    end
  end

  assign push       = cmd.do_byte && (byte_status == ST_QUEUED);
  assign wr_idx_nxt = push ? wr_next : wr_idx_r;
  assign rd_idx_nxt = cmd.do_pop ? rd_next : rd_idx_r;
  assign load_out   = cmd.do_byte || cmd.do_pop || cmd.do_pop_empty;

  always_comb begin
    status_nxt = ST_POP_EMPTY;
    msg_nxt    = '0;
    if (cmd.do_byte) begin
      status_nxt = byte_status;
    end else if (cmd.do_pop) begin
      status_nxt = ST_POPPED;
      msg_nxt    = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FRAME_LOOKBACK; k++) begin
        recent_r[k] <= '0;
      end
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.do_byte) begin
        for (int k = 0; k < FRAME_LOOKBACK - 1; k++) begin
          recent_r[k] <= recent_r[k+1];
        end
        recent_r[FRAME_LOOKBACK-1] <= byte_r;
      end
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_idx_r] <= {recent_r[1], recent_r[2], recent_r[3]};
    end
    if (cmd.rd_issue) begin
      rd_data_r <= queue_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r <= status_nxt;
      msg_r    <= msg_nxt;
      avail_r  <= (wr_idx_nxt != rd_idx_nxt);
    end
  end

  assign sts.item_pop  = (op_r == OP_POP);
  assign sts.q_empty   = q_empty;

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_msg_from  = msg_r[3*BYTE_W-1:2*BYTE_W];
  assign out_msg_to    = msg_r[2*BYTE_W-1:BYTE_W];
  assign out_msg_type  = msg_r[BYTE_W-1:0];
  assign out_available = avail_r;

endmodule

/* rtl/frame_deframer_inbound_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_deframer_inbound_queue
// Delimited frame receiver with destination filter and inbound message queue.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result appears
// on the out_ ports for exactly one cycle with out_valid high, registered
// after the exec state for a received byte or an empty pop, and after the
// exec and pop states for a pop that reads the queue through a register.
// busy is low again in the cycle the result is shown, so the next item is
// taken no earlier than that. The receiver cannot stall: capture each
// result in the cycle out_valid is high. cfg_ready is always high; write
// the registers only while no item is in flight.
module frame_deframer_inbound_queue
  import fdiq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_op,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [BYTE_W-1:0]    out_msg_from,
  output logic [BYTE_W-1:0]    out_msg_to,
  output logic [BYTE_W-1:0]    out_msg_type,
  output logic                 out_available,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  fdiq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  fdiq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_op         (in_op),
    .in_rx_byte    (in_rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_msg_from  (out_msg_from),
    .out_msg_to    (out_msg_to),
    .out_msg_type  (out_msg_type),
    .out_available (out_available)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame deframer with inbound message queue.
// A behavioral model of the frame checks and the ring queue predicts one
// result per accepted item; a checker compares each strobed result field by
// field. Stimulus covers directed frame cases, then random well-formed,
// broken and stray-byte traffic under several register settings, with the
// sender idling at different rates.
// ----------------------------------------------------------------------------
module tb_top;
  import fdiq_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int SEGMENT_LEN  = 115;

  typedef struct {
    status_t             status;
    logic [BYTE_W-1:0]   from;
    logic [BYTE_W-1:0]   to;
    logic [BYTE_W-1:0]   typ;
    logic                avail;
  } msg_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  op_t                  in_op = OP_BYTE;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [BYTE_W-1:0]    out_msg_from;
  logic [BYTE_W-1:0]    out_msg_to;
  logic [BYTE_W-1:0]    out_msg_type;
  logic                 out_available;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_idx_t             cfg_index = CFG_START_BYTE;
  logic [BYTE_W-1:0]    cfg_data = '0;

  // predicted block state
  logic [BYTE_W-1:0]    held_bytes [FRAME_LOOKBACK] = '{default: '0};
  logic [ENTRY_W-1:0]   msg_ring [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_slot = '0;
  logic [QPTR_W-1:0]    rd_slot = '0;
  logic [BYTE_W-1:0]    sof_value = '0;
  logic [BYTE_W-1:0]    eof_value = '0;
  logic [BYTE_W-1:0]    node_addr = '0;

  msg_result_t          expected_msgs [$];
  msg_result_t          head_msg;
  int                   err_count = 0;
  int                   cycle_count = 0;
  int                   items_sent = 0;
  int                   idle_pct = 8;

  frame_deframer_inbound_queue i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_msg_from  (out_msg_from),
    .out_msg_to    (out_msg_to),
    .out_msg_type  (out_msg_type),
    .out_available (out_available),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] s);
    logic [QPTR_W-1:0] n;
    if (s == QPTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = s + QPTR_W'(1);
    end
    return n;
  endfunction

  function automatic msg_result_t deframe(input op_t op, input logic [BYTE_W-1:0] b);
    msg_result_t r;
    r.status = ST_NONE;
    r.from   = '0;
    r.to     = '0;
    r.typ    = '0;
    if (op == OP_BYTE) begin
      if (b == eof_value) begin
        if (held_bytes[0] != sof_value) begin
          r.status = ST_BAD_START;
        end else if (held_bytes[2] != node_addr) begin
          r.status = ST_NOT_FOR_US;
        end else if (next_slot(wr_slot) == rd_slot) begin
          r.status = ST_FULL;
        end else begin
          msg_ring[wr_slot] = {held_bytes[1], held_bytes[2], held_bytes[3]};
          wr_slot = next_slot(wr_slot);
          r.status = ST_QUEUED;
        end
      end
      held_bytes[0] = held_bytes[1];
      held_bytes[1] = held_bytes[2];
      held_bytes[2] = held_bytes[3];
      held_bytes[3] = b;
    end else if (wr_slot == rd_slot) begin
      r.status = ST_POP_EMPTY;
    end else begin
      {r.from, r.to, r.typ} = msg_ring[rd_slot];
      rd_slot = next_slot(rd_slot);
      r.status = ST_POPPED;
    end
    r.avail = (wr_slot != rd_slot);
    return r;
  endfunction

  // predict on every accepted item
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_msgs.push_back(deframe(in_op, in_rx_byte));
    end
  end

  task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                             input logic [BYTE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_msgs.size() == 0) begin
        $error("out_valid: result with no item pending");
        err_count++;
      end else begin
        head_msg = expected_msgs.pop_front();
        check_field("out_status", BYTE_W'(head_msg.status), BYTE_W'(out_status));
        check_field("out_msg_from", head_msg.from, out_msg_from);
        check_field("out_msg_to", head_msg.to, out_msg_to);
        check_field("out_msg_type", head_msg.typ, out_msg_type);
        check_field("out_available", BYTE_W'(head_msg.avail), BYTE_W'(out_available));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(input op_t op, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] sof, input logic [BYTE_W-1:0] from,
                            input logic [BYTE_W-1:0] to, input logic [BYTE_W-1:0] typ,
                            input logic [BYTE_W-1:0] eof);
    send_item(OP_BYTE, sof);
    send_item(OP_BYTE, from);
    send_item(OP_BYTE, to);
    send_item(OP_BYTE, typ);
    send_item(OP_BYTE, eof);
  endtask

  // hold off until every result is in and the block is quiet
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_BYTE: sof_value = data;
      CFG_END_BYTE: eof_value = data;
      CFG_NODE_ADDRESS: node_addr = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] sof, input logic [BYTE_W-1:0] eof,
                            input logic [BYTE_W-1:0] addr);
    write_reg(CFG_START_BYTE, sof);
    write_reg(CFG_END_BYTE, eof);
    write_reg(CFG_NODE_ADDRESS, addr);
    cfg_valid <= 1'b0;
  endtask

  // reset settings: every zero byte closes a valid frame, so the queue fills
  task automatic test_reset_frames();
    idle_pct = 8;
    send_item(OP_POP, 8'hFF);
    repeat (8) send_item(OP_BYTE, 8'h00);
    send_item(OP_POP, 8'h00);
  endtask

  task automatic test_frame_checks();
    wait_drained();
    set_config(8'hFF, 8'hFE, 8'h80);
    send_frame(8'hFF, 8'h01, 8'h80, 8'h02, 8'hFE);
    send_item(OP_BYTE, 8'hFE);
    send_frame(8'hFF, 8'h01, 8'h81, 8'h02, 8'hFE);
  endtask

  task automatic random_traffic(input int n_items);
    int base;
    int sel;
    bit paused;
    logic [BYTE_W-1:0] sof;
    logic [BYTE_W-1:0] to;
    base   = items_sent;
    paused = 1'b0;
    while (items_sent - base < n_items) begin
      if (!paused && items_sent - base >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 50) begin
        sof = ($urandom_range(9) < 9) ? sof_value : 8'($urandom_range(255));
        to  = ($urandom_range(9) < 8) ? node_addr : 8'($urandom_range(255));
        send_frame(sof, 8'($urandom_range(255)), to, 8'($urandom_range(255)), eof_value);
      end else if (sel < 56) begin
        // truncated frame
        send_item(OP_BYTE, sof_value);
        send_item(OP_BYTE, 8'($urandom_range(255)));
      end else if (sel < 82) begin
        send_item(OP_POP, 8'($urandom_range(255)));
      end else if (sel < 92) begin
        send_item(OP_BYTE, 8'($urandom_range(255)));
      end else begin
        send_item(OP_BYTE, eof_value);
      end
    end
  endtask

  task automatic test_random(input int pct);
    logic [BYTE_W-1:0] sof;
    idle_pct = pct;
    for (int mode = 0; mode < 4; mode++) begin
      wait_drained();
      sof = 8'($urandom_range(255));
      case (mode)
        0: set_config(8'h00, 8'hFF, 8'h00);
        1: set_config(8'hFF, 8'h00, 8'hFF);
        2: set_config(sof, 8'($urandom_range(255)), 8'($urandom_range(255)));
        default: set_config(sof, sof, 8'($urandom_range(255)));
      endcase
      random_traffic(SEGMENT_LEN);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_frames();
    test_frame_checks();
    test_random(8);
    test_random(64);
    test_random(0);
    wait_drained();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
